// ----- rtl/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

    localparam int CLUSTERS_DEF          = 8;
    localparam int SLOTS_PER_CLUSTER_DEF = 256;
    localparam int WORD_BITS_DEF         = 64;

    localparam int SLOT_W        = 11;
    localparam int KIND_W        = 2;
    localparam int RESERVED_BITS = 16;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              status;
    } t_rsp;

endpackage

// ----- rtl/bsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsa_ram import bsa_pkg::*; #(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = CLUSTERS_DEF * SLOTS_PER_CLUSTER_DEF / WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bitmap_slot_allocator.sv -----
// Bitmap slot allocator: top level with scan sequencer over the usage bitmap RAM.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one command beat:
// allocate, free or sweep. Output channel (o_out_valid / i_out_stall / o_out_data)
// returns exactly one beat per command: the granted slot and a status bit.
// The bitmap lives in one RAM of CLUSTERS*WORDS words, read one word per cycle.
// Allocate streams words from the hint cluster up; a newly activated cluster is
// initialized before its result. Sweep always reads every word. Free is a
// read-modify-write of one word, with no write for a reserved slot or a slot
// outside the live clusters. The single RAM read port allows one command in
// flight at a time; o_in_stall is high until it has finished.
// A new command may be accepted while the previous result still waits in the
// output register; its result is then held until the receiver takes the old one.
// After reset the block writes cluster 0's bitmap word by word (input stalled
// meanwhile); cluster 0 is live and the hint is cluster 0.
// While i_out_stall is high the output beat holds steady.
module bitmap_slot_allocator import bsa_pkg::*; #(
    parameter int CLUSTERS          = CLUSTERS_DEF,
    parameter int SLOTS_PER_CLUSTER = SLOTS_PER_CLUSTER_DEF,
    parameter int WORD_BITS         = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_cmd i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam int WORDS = SLOTS_PER_CLUSTER / WORD_BITS;
    localparam int TOTAL = CLUSTERS * WORDS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(CLUSTERS);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int WSH   = $clog2(WORDS);
    localparam int SBW   = $clog2(SLOTS_PER_CLUSTER);

    localparam logic [AW-1:0]        LAST_ADDR = AW'(TOTAL - 1);
    localparam logic [AW-1:0]        WORD_MASK = AW'(WORDS - 1);
    localparam logic [WORD_BITS-1:0] RES_MASK  = WORD_BITS'(64'd1 << RESERVED_BITS) - 1'b1;
    localparam logic [WORD_BITS-1:0] GRANT_BIT = WORD_BITS'(64'd1 << RESERVED_BITS);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_FREE_RD = 7'b0000100,
        S_FREE_WR = 7'b0001000,
        S_SWEEP   = 7'b0010000,
        S_FILL    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    function automatic logic [BW-1:0] enc_bit(input logic [WORD_BITS-1:0] oh);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                idx = idx | BW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [CW-1:0] enc_cl(input logic [CLUSTERS-1:0] oh);
        logic [CW-1:0] idx;
        idx = '0;
        for (int i = 0; i < CLUSTERS; i++) begin
            if (oh[i]) begin
                idx = idx | CW'(i);
            end
        end
        return idx;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_tag, n_tag;
    logic                r_pend, n_pend;
    logic                r_issue_done, n_issue_done;
    logic [CLUSTERS-1:0] r_live, n_live;
    logic [CW-1:0]       r_hint, n_hint;
    logic                r_grant, n_grant;
    logic                r_kept, n_kept;
    logic                r_sethint, n_sethint;
    logic                r_acc_empty, n_acc_empty;
    logic                r_acc_full, n_acc_full;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    t_rsp                r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] q;

    logic [CW-1:0]        tc;
    logic [AW-1:0]        tw;
    logic                 first_word;
    logic                 last_word;
    logic                 word_full;
    logic                 word_empty;
    logic                 cl_empty;
    logic                 cl_full;
    logic [WORD_BITS-1:0] zero_oh;
    logic [BW-1:0]        zero_idx;
    logic [CLUSTERS-1:0]  dead_oh;
    logic [CW-1:0]        first_dead;
    logic [AW-1:0]        dead_base;
    logic [CLUSTERS-1:0]  above;
    logic [CLUSTERS-1:0]  above_live;
    logic [CLUSTERS-1:0]  next_oh;
    logic [CW-1:0]        next_cl;
    logic [SLOT_W-1:0]    f_cl_wide;
    logic [SLOT_W-1:0]    f_idx;
    logic [CW-1:0]        f_cl;
    logic [AW-1:0]        f_addr;
    logic [BW-1:0]        f_bit;
    logic                 f_ok;
    logic [AW-1:0]        fill_word;

    bsa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (q)
    );

    assign tc         = CW'(r_tag >> WSH);
    assign tw         = r_tag & WORD_MASK;
    assign first_word = (tw == '0);
    assign last_word  = (tw == WORD_MASK);
    assign word_full  = (q == '1);
    assign word_empty = first_word ? ((q & ~RES_MASK) == '0) : (q == '0);
    assign cl_empty   = (first_word ? 1'b1 : r_acc_empty) & word_empty;
    assign cl_full    = (first_word ? 1'b1 : r_acc_full) & word_full;

    assign zero_oh  = ~q & (q + WORD_BITS'(1));
    assign zero_idx = enc_bit(zero_oh);

    assign dead_oh    = ~r_live & (r_live + CLUSTERS'(1));
    assign first_dead = enc_cl(dead_oh);
    assign dead_base  = AW'(first_dead) << WSH;

    always_comb begin
        for (int n = 0; n < CLUSTERS; n++) begin
            above[n] = (n > int'(tc));
        end
    end
    assign above_live = r_live & above;
    assign next_oh    = above_live & (~above_live + CLUSTERS'(1));
    assign next_cl    = enc_cl(next_oh);

    assign f_cl_wide = r_slot >> SBW;
    assign f_idx     = r_slot & SLOT_W'(SLOTS_PER_CLUSTER - 1);
    assign f_cl      = CW'(f_cl_wide);
    assign f_addr    = AW'(r_slot >> BW);
    assign f_bit     = r_slot[BW-1:0];
    assign f_ok      = (f_cl_wide < SLOT_W'(CLUSTERS)) && r_live[f_cl]
                       && (f_idx >= SLOT_W'(RESERVED_BITS));

    assign fill_word = r_addr & WORD_MASK;
    assign ram_raddr = (r_state == S_FREE_RD) ? f_addr : r_addr;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_tag        = r_tag;
        n_pend       = r_pend;
        n_issue_done = r_issue_done;
        n_live       = r_live;
        n_hint       = r_hint;
        n_grant      = r_grant;
        n_kept       = r_kept;
        n_sethint    = r_sethint;
        n_acc_empty  = r_acc_empty;
        n_acc_full   = r_acc_full;
        n_slot       = r_slot;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_slot       = i_in_data.slot;
                    n_res        = '0;
                    n_pend       = 1'b0;
                    n_issue_done = 1'b0;
                    n_kept       = 1'b0;
                    n_sethint    = 1'b0;
                    n_addr       = AW'(r_hint) << WSH;
                    unique case (i_in_data.kind)
                        KIND_ALLOC: n_state = S_SCAN;
                        KIND_FREE:  n_state = S_FREE_RD;
                        KIND_SWEEP: begin
                            n_addr  = '0;
                            n_state = S_SWEEP;
                        end
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                n_pend = !r_issue_done;
                n_tag  = r_addr;
                if (!r_issue_done) begin
                    if (r_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_pend) begin
                    if (r_live[tc] && !word_full) begin
                        ram_we             = 1'b1;
                        ram_waddr          = r_tag;
                        ram_wdata          = q | zero_oh;
                        n_res.granted_slot = SLOT_W'({r_tag, zero_idx});
                        n_hint             = tc;
                        n_state            = S_DONE;
                    end else if (r_tag == LAST_ADDR) begin
                        if (r_live != '1) begin
                            n_live             = r_live | dead_oh;
                            n_hint             = first_dead;
                            n_res.granted_slot =
                                SLOT_W'({dead_base, BW'(RESERVED_BITS)});
                            n_addr             = dead_base;
                            n_grant            = 1'b1;
                            n_state            = S_FILL;
                        end else begin
                            n_res.status = STATUS_FULL;
                            n_state      = S_DONE;
                        end
                    end
                end
            end
            S_FREE_RD: begin
                n_state = f_ok ? S_FREE_WR : S_DONE;
            end
            S_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr;
                ram_wdata = q & ~(WORD_BITS'(1) << f_bit);
                if (f_cl < r_hint) begin
                    n_hint = f_cl;
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                n_pend = !r_issue_done;
                n_tag  = r_addr;
                if (!r_issue_done) begin
                    if (r_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_pend) begin
                    n_acc_empty = cl_empty;
                    n_acc_full  = cl_full;
                    if (last_word && r_live[tc]) begin
                        if (cl_empty) begin
                            if (!r_kept) begin
                                n_kept    = 1'b1;
                                n_sethint = 1'b1;
                                n_hint    = tc;
                            end else begin
                                n_live[tc] = 1'b0;
                                if (r_hint == tc) begin
                                    n_hint = next_cl;
                                end
                            end
                        end else if (cl_full && !r_sethint) begin
                            n_sethint = 1'b1;
                            n_hint    = tc;
                        end
                    end
                    if (r_tag == LAST_ADDR) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FILL: begin
                // word 0 carries the reserved bits, plus the granted slot on activation
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = (fill_word == '0) ? (RES_MASK | (r_grant ? GRANT_BIT : '0)) : '0;
                if (fill_word == WORD_MASK) begin
                    n_state = r_grant ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b0;
            r_live       <= CLUSTERS'(1);
            r_hint       <= '0;
            r_grant      <= 1'b0;
            r_kept       <= 1'b0;
            r_sethint    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_pend       <= n_pend;
            r_issue_done <= n_issue_done;
            r_live       <= n_live;
            r_hint       <= n_hint;
            r_grant      <= n_grant;
            r_kept       <= n_kept;
            r_sethint    <= n_sethint;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_acc_empty <= n_acc_empty;
        r_acc_full  <= n_acc_full;
        r_slot      <= n_slot;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for bitmap_slot_allocator: random handshakes, in-order result scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsa_pkg::*;

    localparam int CL     = CLUSTERS_DEF;
    localparam int SPC    = SLOTS_PER_CLUSTER_DEF;
    localparam int WB     = WORD_BITS_DEF;
    localparam int WORDS  = SPC / WB;
    localparam int NSLOTS = CL * SPC;
    localparam int HALF   = 10;
    localparam int LIMIT  = 1000000;
    localparam int TAIL   = 2 * (CL * WORDS + WORDS + 3) + 40;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [WB-1:0] RESV_MASK = WB'((64'd1 << RESERVED_BITS) - 1);

    typedef enum logic [1:0] {PICK_NONE, PICK_ANY, PICK_TOP} t_pick;
    typedef struct {
        t_cmd  cmd;
        t_pick pick;
    } t_op_req;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_vld      = 1'b0;
    t_cmd in_data     = '0;
    logic out_stall   = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;

    bitmap_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #(HALF) i_clk = ~i_clk;

    // allocator shadow state
    bit [WB-1:0] usage_m [CL*WORDS];
    bit [CL-1:0] live_m;
    int          hint_m;

    t_op_req cmd_q [$];
    t_rsp    due_rsp_q [$];
    t_op_req next_req;
    bit      in_fire;
    bit      quiet;
    int      send_gap;
    int      stall_left;
    int      cycles;
    int      n_pushed, n_acc, err_cnt;
    int      n_grant, n_full, n_free, n_sweep, n_other;

    function automatic bit slot_used(int s);
        int cl, idx;
        cl  = s / SPC;
        idx = s % SPC;
        return live_m[cl] && idx >= RESERVED_BITS && usage_m[cl*WORDS + idx/WB][idx%WB];
    endfunction

    function automatic bit take_in(int c, output logic [SLOT_W-1:0] g);
        bit [WB-1:0] v;
        int j;
        for (int w = 0; w < WORDS; w++) begin
            v = usage_m[c*WORDS + w];
            if (v != '1) begin
                j = WB - 1;
                for (int b = WB - 2; b >= 0; b--)
                    if (!v[b]) j = b;
                v[j] = 1'b1;
                usage_m[c*WORDS + w] = v;
                g = SLOT_W'(c*SPC + w*WB + j);
                return 1'b1;
            end
        end
        g = '0;
        return 1'b0;
    endfunction

    function automatic bit cluster_empty(int c);
        if ((usage_m[c*WORDS] & ~RESV_MASK) != '0) return 1'b0;
        for (int w = 1; w < WORDS; w++)
            if (usage_m[c*WORDS + w] != '0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit cluster_full(int c);
        for (int w = 0; w < WORDS; w++)
            if (usage_m[c*WORDS + w] != '1) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void sweep_clusters();
        bit kept, set_hint;
        kept     = 1'b0;
        set_hint = 1'b0;
        for (int c = 0; c < CL; c++) begin
            if (live_m[c]) begin
                if (cluster_empty(c)) begin
                    if (!kept) begin
                        kept     = 1'b1;
                        set_hint = 1'b1;
                        hint_m   = c;
                    end else begin
                        live_m[c] = 1'b0;
                        for (int w = 0; w < WORDS; w++) usage_m[c*WORDS + w] = '0;
                        if (hint_m == c) begin
                            hint_m = 0;
                            for (int n = c + 1; n < CL; n++)
                                if (live_m[n]) begin
                                    hint_m = n;
                                    break;
                                end
                        end
                    end
                end else if (cluster_full(c) && !set_hint) begin
                    set_hint = 1'b1;
                    hint_m   = c;
                end
            end
        end
    endfunction

    task automatic allocator_step(input t_cmd cmd, output t_rsp rsp);
        logic [SLOT_W-1:0] g;
        bit done;
        int c, cl, idx;
        g          = '0;
        done       = 1'b0;
        rsp.status = STATUS_DONE;
        case (cmd.kind)
            KIND_ALLOC: begin
                for (c = hint_m; c < CL && !done; c++)
                    if (live_m[c])
                        if (take_in(c, g)) begin
                            hint_m = c;
                            done   = 1'b1;
                        end
                if (!done) begin
                    c = 0;
                    while (c < CL && live_m[c]) c++;
                    if (c < CL) begin
                        live_m[c] = 1'b1;
                        for (int w = 0; w < WORDS; w++) usage_m[c*WORDS + w] = '0;
                        usage_m[c*WORDS] = RESV_MASK;
                        void'(take_in(c, g));
                        hint_m = c;
                    end else begin
                        g          = '0;
                        rsp.status = STATUS_FULL;
                    end
                end
                if (rsp.status == STATUS_FULL) n_full++;
                else n_grant++;
            end
            KIND_FREE: begin
                cl  = cmd.slot / SPC;
                idx = cmd.slot % SPC;
                if (cl < CL && live_m[cl] && idx >= RESERVED_BITS) begin
                    usage_m[cl*WORDS + idx/WB][idx%WB] = 1'b0;
                    if (cl < hint_m) hint_m = cl;
                end
                n_free++;
            end
            KIND_SWEEP: begin
                sweep_clusters();
                n_sweep++;
            end
            default: n_other++;
        endcase
        rsp.granted_slot = g;
    endtask

    // used slot at random, anywhere or in the highest cluster still holding one
    function automatic logic [SLOT_W-1:0] pick_slot(t_pick mode);
        int lo, span, start, s;
        lo   = 0;
        span = NSLOTS;
        if (mode == PICK_TOP) begin
            for (int c = 0; c < CL; c++)
                if (live_m[c] && !cluster_empty(c)) lo = c * SPC;
            span = SPC;
        end
        start = $urandom_range(span - 1);
        for (int k = 0; k < span; k++) begin
            s = lo + (start + k) % span;
            if (slot_used(s)) return SLOT_W'(s);
        end
        return SLOT_W'($urandom_range(NSLOTS - 1));
    endfunction

    // used slots in the two highest live clusters that still hold any
    function automatic int top_used();
        int n, k;
        n = 0;
        k = 0;
        for (int c = CL - 1; c >= 0; c--) begin
            if (k < 2 && live_m[c] && !cluster_empty(c)) begin
                k++;
                for (int i = RESERVED_BITS; i < SPC; i++)
                    if (slot_used(c*SPC + i)) n++;
            end
        end
        return n;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s: expected %0d, got %0d (beat %0d)",
                         name, exp_v, act_v, n_acc);
        end
    endtask

    // driver: request side
    always @(negedge i_clk) begin
        if (!in_vld || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                in_vld <= 1'b0;
            end else if (cmd_q.size() != 0 && !quiet && $urandom_range(7) == 0) begin
                send_gap = $urandom_range(14);
                in_vld   <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                next_req = cmd_q.pop_front();
                if (next_req.pick != PICK_NONE) next_req.cmd.slot = pick_slot(next_req.pick);
                in_data <= next_req.cmd;
                in_vld  <= 1'b1;
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // driver: response back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(9) == 0) begin
            stall_left = $urandom_range(14);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp rsp_exp;
        in_fire = in_vld && !o_in_stall;
        if (in_fire) begin
            allocator_step(in_data, rsp_exp);
            due_rsp_q.push_back(rsp_exp);
            n_acc++;
        end
        if (o_out_valid && !out_stall) begin
            if (due_rsp_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: slot %0d status %0d",
                             o_out_data.granted_slot, o_out_data.status);
            end else begin
                rsp_exp = due_rsp_q.pop_front();
                check_field("granted_slot", int'(rsp_exp.granted_slot),
                            int'(o_out_data.granted_slot));
                check_field("status", int'(rsp_exp.status), int'(o_out_data.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, due_rsp_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(logic [KIND_W-1:0] k, int s, t_pick p);
        t_op_req r;
        r.cmd.kind = k;
        r.cmd.slot = SLOT_W'(s);
        r.pick     = p;
        cmd_q.push_back(r);
        n_pushed++;
    endtask

    task automatic push_mix(int n, int p_alloc, int p_free, int p_sweep, t_pick fpick);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < p_alloc)
                push_cmd(KIND_ALLOC, $urandom_range(NSLOTS - 1), PICK_NONE);
            else if (r < p_alloc + p_free)
                push_cmd(KIND_FREE, 0, fpick);
            else if (r < p_alloc + p_free + p_sweep)
                push_cmd(KIND_SWEEP, $urandom_range(NSLOTS - 1), PICK_NONE);
            else if (r[0])
                push_cmd(KIND_NONE, $urandom_range(NSLOTS - 1), PICK_NONE);
            else
                push_cmd(KIND_FREE, $urandom_range(NSLOTS - 1), PICK_NONE);
        end
    endtask

    task automatic wait_idle();
        while (n_acc != n_pushed || due_rsp_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int drain_n;
        for (int i = 0; i < CL * WORDS; i++) usage_m[i] = '0;
        usage_m[0] = RESV_MASK;
        live_m     = CL'(1);
        hint_m     = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        push_cmd(KIND_ALLOC, 0, PICK_NONE);
        push_cmd(KIND_ALLOC, NSLOTS - 1, PICK_NONE);
        push_cmd(KIND_FREE, RESERVED_BITS, PICK_NONE);
        push_cmd(KIND_FREE, RESERVED_BITS, PICK_NONE);      // already free
        push_cmd(KIND_FREE, 0, PICK_NONE);                  // reserved
        push_cmd(KIND_FREE, RESERVED_BITS - 1, PICK_NONE);  // reserved edge
        push_cmd(KIND_FREE, NSLOTS - 1, PICK_NONE);         // cluster not live
        push_cmd(KIND_FREE, SPC, PICK_NONE);
        push_cmd(KIND_NONE, NSLOTS - 1, PICK_NONE);
        push_cmd(KIND_NONE, 0, PICK_NONE);
        push_cmd(KIND_SWEEP, 0, PICK_NONE);
        push_cmd(KIND_FREE, RESERVED_BITS + 1, PICK_NONE);
        push_cmd(KIND_SWEEP, NSLOTS - 1, PICK_NONE);        // lone empty cluster kept
        push_cmd(KIND_ALLOC, NSLOTS - 1, PICK_NONE);
        push_cmd(KIND_FREE, SPC - 1, PICK_NONE);
        push_cmd(KIND_FREE, WB - 1, PICK_NONE);
        push_cmd(KIND_ALLOC, 0, PICK_NONE);
        push_cmd(KIND_FREE, RESERVED_BITS, PICK_NONE);
        push_cmd(KIND_ALLOC, 0, PICK_NONE);
        push_cmd(KIND_SWEEP, 0, PICK_NONE);
        wait_idle();

        push_mix(150, 60, 30, 5, PICK_ANY);
        wait_idle();

        // fill the lower clusters, then sweep and free against the full ones
        repeat (700) push_cmd(KIND_ALLOC, $urandom_range(NSLOTS - 1), PICK_NONE);
        push_cmd(KIND_SWEEP, 0, PICK_NONE);
        push_cmd(KIND_ALLOC, 0, PICK_NONE);
        repeat (4) push_cmd(KIND_FREE, 0, PICK_ANY);
        repeat (6) push_cmd(KIND_ALLOC, 0, PICK_NONE);
        push_cmd(KIND_SWEEP, 0, PICK_NONE);
        push_mix(20, 50, 40, 10, PICK_ANY);
        wait_idle();

        // empty the two upper clusters so a sweep releases one of them
        drain_n = top_used();
        repeat (drain_n) push_cmd(KIND_FREE, 0, PICK_TOP);
        repeat (2) push_cmd(KIND_SWEEP, 0, PICK_NONE);
        push_mix(150, 45, 45, 5, PICK_ANY);
        wait_idle();

        quiet = 1'b1;
        push_mix(120, 50, 40, 5, PICK_ANY);
        wait_idle();
        repeat (TAIL) @(negedge i_clk);

        $display("%0d beats: %0d grants, %0d refused as full, %0d frees, %0d sweeps, %0d other",
                 n_acc, n_grant, n_full, n_free, n_sweep, n_other);
        $display("lower clusters filled, two upper clusters emptied and released by sweeps");
        if (err_cnt == 0 && due_rsp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d beats missing", err_cnt, due_rsp_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
